[design/assert_macros.svh]
// Assertion macros used by combined_lfsr_bounded_random.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[design/clbr_pkg.sv]
// Types and constants of the combined LFSR bounded random generator.
package clbr_pkg;

    // Default cap on the number of random bits in one draw round
    localparam int unsigned MaxDrawBitsDef = 31;

    // Rejected rounds after which a draw saturates to its limit
    localparam int unsigned RoundCap = 32;
    localparam int unsigned RoundW   = $clog2(RoundCap);

    // Request opcodes
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    // Request beat
    typedef struct packed {
        logic        opcode;
        logic [31:0] limit;
        logic [31:0] seed_first;
        logic [30:0] seed_second;
        logic [28:0] seed_third;
    } t_req;

    // Response beat
    typedef struct packed {
        logic [31:0] value;
        logic        bad_limit;
        logic [31:0] now_first;
        logic [30:0] now_second;
        logic [28:0] now_third;
    } t_rsp;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAW,
        ST_FIN
    } t_state;

endpackage

[design/clbr_stream_if.sv]
// Valid/ready stream channel carrying one payload beat.
interface clbr_stream_if #(
    parameter type t_data = logic
) ();
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/combined_lfsr_bounded_random.sv]
// Combined three-LFSR generator with bounded, rejection-sampled draws.
//
//  channel | dir | beat  | payload
//  --------+-----+-------+-------------------------------------------------
//  i_req   | in  | t_req | opcode, limit, seed_first/second/third
//  o_rsp   | out | t_rsp | value, bad_limit, now_first/second/third
//
// Seed request or zero limit: the beat goes straight to ST_FIN, then to the output register.
// Draw with limit N: k = ceil(log2 N) capped at MAX_DRAW_BITS; each round steps all three LFSRs
// once per bit, then does the accept check, for up to 32 rounds; then ST_FIN hands the result
// off and the block returns to ST_IDLE before it takes the next beat.
// Reset clears all three LFSRs and the control state. A finished result waits in place while
// the output register is full; no new request is taken until it has moved there.
`include "assert_macros.svh"

module combined_lfsr_bounded_random #(
    parameter int unsigned MAX_DRAW_BITS = clbr_pkg::MaxDrawBitsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    clbr_stream_if.sink          i_req,
    clbr_stream_if.source        o_rsp
);
    import clbr_pkg::*;

    localparam int unsigned StepW = $clog2(MAX_DRAW_BITS + 1);

    // state
    t_state           r_state, n_state;
    logic [31:0]      r_first, n_first;
    logic [30:0]      r_second, n_second;
    logic [28:0]      r_third, n_third;
    logic [31:0]      r_lim, n_lim;
    logic [31:0]      r_rem, n_rem;
    logic             r_le, n_le;
    logic [31:0]      r_acc, n_acc;
    logic [31:0]      r_mask, n_mask;
    logic [StepW-1:0] r_step, n_step;
    logic [RoundW-1:0] r_round, n_round;
    logic [31:0]      r_value, n_value;
    logic             r_bad, n_bad;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_out, n_out;

    logic        req_acc;
    logic        out_free;
    logic        round_end;
    logic        round_ok;
    logic        round_last;
    logic [31:0] first_nx;
    logic [30:0] second_nx;
    logic [28:0] third_nx;
    logic        rnd_bit;

    // handshake
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // one step of each LFSR, random bit from the new low bits
    assign first_nx  = {r_first[31] ^ r_first[6] ^ r_first[4] ^ r_first[2] ^ r_first[0],
                        r_first[31:1]};
    assign second_nx = {r_second[30] ^ r_second[2], r_second[30:1]};
    assign third_nx  = {r_third[28] ^ r_third[1], r_third[28:1]};
    assign rnd_bit   = first_nx[0] ^ second_nx[0] ^ third_nx[0];

    // round ends once limit-1 is shifted out or the bit cap is hit;
    // value fits when the serial compare says sum <= limit-1 or limit-1 has high bits left
    assign round_end  = (r_rem == '0) || (r_step == StepW'(MAX_DRAW_BITS));
    assign round_ok   = r_le || (r_rem != '0);
    assign round_last = (r_round == RoundW'(RoundCap - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    if (i_req.data.opcode == OP_DRAW && i_req.data.limit != '0) begin
                        n_state = ST_DRAW;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_DRAW: begin
                if (round_end && (round_ok || round_last)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_first     = r_first;
        n_second    = r_second;
        n_third     = r_third;
        n_lim       = r_lim;
        n_rem       = r_rem;
        n_le        = r_le;
        n_acc       = r_acc;
        n_mask      = r_mask;
        n_step      = r_step;
        n_round     = r_round;
        n_value     = r_value;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_lim   = i_req.data.limit;
                    n_rem   = i_req.data.limit - 32'd1;
                    n_le    = 1'b1;
                    n_acc   = '0;
                    n_mask  = 32'd1;
                    n_step  = '0;
                    n_round = '0;
                    n_value = '0;
                    n_bad   = (i_req.data.opcode == OP_DRAW) && (i_req.data.limit == '0);
                    if (i_req.data.opcode == OP_SEED) begin
                        n_first  = i_req.data.seed_first;
                        n_second = i_req.data.seed_second;
                        n_third  = i_req.data.seed_third;
                    end
                end
            end
            ST_DRAW: begin
                if (round_end) begin
                    if (round_ok) begin
                        n_value = r_acc + 32'd1;
                    end else if (round_last) begin
                        n_value = r_lim;
                    end else begin
                        // restart the round
                        n_rem   = r_lim - 32'd1;
                        n_le    = 1'b1;
                        n_acc   = '0;
                        n_mask  = 32'd1;
                        n_step  = '0;
                        n_round = r_round + RoundW'(1);
                    end
                end else begin
                    // one bit: step LFSRs, fold bit into sum and serial compare
                    n_first  = first_nx;
                    n_second = second_nx;
                    n_third  = third_nx;
                    n_acc    = r_acc | (r_mask & {32{rnd_bit}});
                    n_mask   = {r_mask[30:0], 1'b0};
                    n_le     = (rnd_bit ^ r_rem[0]) ? r_rem[0] : r_le;
                    n_rem    = {1'b0, r_rem[31:1]};
                    n_step   = r_step + StepW'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.value      = r_value;
                    n_out.bad_limit  = r_bad;
                    n_out.now_first  = r_first;
                    n_out.now_second = r_second;
                    n_out.now_third  = r_third;
                end
            end
            default: ;
        endcase
    end

    // control and LFSR registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_first     <= '0;
            r_second    <= '0;
            r_third     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_first     <= n_first;
            r_second    <= n_second;
            r_third     <= n_third;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_lim   <= n_lim;
        r_rem   <= n_rem;
        r_le    <= n_le;
        r_acc   <= n_acc;
        r_mask  <= n_mask;
        r_step  <= n_step;
        r_round <= n_round;
        r_value <= n_value;
        r_bad   <= n_bad;
        r_out   <= n_out;
    end

    // checks
    `ASSERT_IMPLIES(a_bad_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.data.bad_limit, o_rsp.data.value == '0, "bad limit beat with nonzero value")
    `ASSERT_NEXT(a_seed_load, i_clk, i_rst_n, req_acc && i_req.data.opcode == OP_SEED, r_first == $past(i_req.data.seed_first) && r_third == $past(i_req.data.seed_third), "seed not loaded")
    `ASSERT_IMPLIES(a_step_cap, i_clk, i_rst_n, r_state == ST_DRAW, r_step <= StepW'(MAX_DRAW_BITS), "draw step count past cap")
    `ASSERT_IMPLIES(a_out_src, i_clk, i_rst_n, o_rsp.valid && !$past(o_rsp.valid), $past(r_state) == ST_FIN, "result loaded outside hand-off")

endmodule
